FILE: design/mbrtu_pkg.sv
// Shared types, constants and the CRC16 byte step for the Modbus RTU master.
package mbrtu_pkg;

  // Input item codes.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RX    = 2'd2,
    FUNC_END   = 2'd3
  } func_e;

  // Kind of request that waits for its response.
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_READ  = 2'd1,
    PEND_WRITE = 2'd2
  } pend_e;

  // Completion status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_CRC   = 3'd2,
    ST_ADDR  = 3'd3,
    ST_FUNC  = 3'd4,
    ST_FRAME = 3'd5
  } status_e;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_REQ  = 1'b1
  } back_state_e;

  // Result kinds.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register index (word index on the APB port).
  localparam logic REG_SLAVE_ADDR = 1'b0;

  // Modbus protocol constants.
  localparam logic [7:0]  FC_READ      = 8'h03;
  localparam logic [7:0]  FC_WRITE     = 8'h06;
  localparam logic [15:0] READ_START   = 16'h001E;
  localparam logic [15:0] READ_COUNT   = 16'h0003;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FC_MASK      = 8'h7F;
  localparam logic [7:0]  FC_EXC_BIT   = 8'h80;
  localparam int          MIN_LEN      = 5;
  localparam int          READ_LEN     = 11;
  localparam int          WRITE_LEN    = 8;
  localparam int          PAYLOAD_LEN  = 6;
  localparam int          PAYLOAD_POS  = 3;
  localparam logic [2:0]  REQ_LAST_IDX = 3'd7;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // One queued command: a request to transmit or a finished transaction.
  typedef struct packed {
    logic        done;
    status_e     status;
    logic [7:0]  fcode;
    logic [15:0] d0;
    logic [15:0] d1;
    logic [15:0] d2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One byte of the Modbus CRC16, reflected polynomial, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mbrtu_if.sv
// Valid/ready stream interfaces for the input items and the result beats.
interface mbrtu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] register_address;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, func, register_address, write_value, rx_byte,
                  input ready);
  modport sink   (input valid, func, register_address, write_value, rx_byte,
                  output ready);
endinterface

interface mbrtu_rsp_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         tx_byte;
  logic               last;
  logic [2:0]         status;
  logic signed [15:0] nitrogen;
  logic signed [15:0] phosphorus;
  logic signed [15:0] potassium;

  modport source (output valid, kind, tx_byte, last, status, nitrogen, phosphorus,
                  potassium, input ready);
  modport sink   (input valid, kind, tx_byte, last, status, nitrogen, phosphorus,
                  potassium, output ready);
endinterface

FILE: design/mbrtu_cmd_fifo.sv
// Small command queue between the front and back ends.
module mbrtu_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mbrtu_pkg::cmd_t     entry_i,
  input  logic                pop_i,
  output mbrtu_pkg::cmd_t     head_o,
  output mbrtu_pkg::q_status_t stat_o
);

  mbrtu_pkg::cmd_t                mem_q [mbrtu_pkg::QDEPTH];
  logic [mbrtu_pkg::QPTR_W-1:0]   wr_q, wr_d;
  logic [mbrtu_pkg::QPTR_W-1:0]   rd_q, rd_d;
  logic [mbrtu_pkg::QPTR_W:0]     cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (mbrtu_pkg::QPTR_W+1)'(mbrtu_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: design/mbrtu_front.sv
// Front end: accepts items, tracks the received frame and queues commands.
module mbrtu_front #(
  parameter int MAX_FRAME_BYTES = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mbrtu_req_if.sink            req_i,
  input  logic [7:0]           slave_addr_i,
  input  mbrtu_pkg::q_status_t q_stat_i,
  output logic                 q_push_o,
  output mbrtu_pkg::cmd_t      q_entry_o
);

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_FRAME_BYTES);
  localparam logic [CntW-1:0] MinCnt   = CntW'(mbrtu_pkg::MIN_LEN);
  localparam logic [CntW-1:0] ReadCnt  = CntW'(mbrtu_pkg::READ_LEN);
  localparam logic [CntW-1:0] WriteCnt = CntW'(mbrtu_pkg::WRITE_LEN);

  mbrtu_pkg::func_e   func;
  logic               accept;
  mbrtu_pkg::pend_e   pend_q, pend_d;
  logic [15:0]        rreg_q, rreg_d;
  logic [15:0]        rval_q, rval_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [15:0]        crc_q, crc_d;
  logic [15:0]        tail_q, tail_d;
  logic [15:0]        head_q, head_d;
  logic [7:0]         pay_q [mbrtu_pkg::PAYLOAD_LEN];
  logic [7:0]         pay_d [mbrtu_pkg::PAYLOAD_LEN];
  logic               mism_q, mism_d;
  logic               func_match;
  mbrtu_pkg::status_e status;
  logic               data_ok;

  assign func   = mbrtu_pkg::func_e'(req_i.func);
  // Received bytes never need a queue slot, so they pass even when it is full.
  assign req_i.ready = !q_stat_i.full || (func == mbrtu_pkg::FUNC_RX);
  assign accept = req_i.valid && req_i.ready;

  // Completion status, checked in priority order.
  always_comb begin
    func_match = ((pend_q == mbrtu_pkg::PEND_READ) &&
                  ((head_q[7:0] & mbrtu_pkg::FC_MASK) == mbrtu_pkg::FC_READ)) ||
                 ((pend_q == mbrtu_pkg::PEND_WRITE) &&
                  ((head_q[7:0] & mbrtu_pkg::FC_MASK) == mbrtu_pkg::FC_WRITE));
    data_ok = 1'b0;
    if (cnt_q < MinCnt) begin
      status = mbrtu_pkg::ST_SHORT;
    end else if (crc_q != tail_q) begin
      status = mbrtu_pkg::ST_CRC;
    end else if (head_q[15:8] != slave_addr_i) begin
      status = mbrtu_pkg::ST_ADDR;
    end else if (!func_match) begin
      status = mbrtu_pkg::ST_FUNC;
    end else if ((head_q[7:0] & mbrtu_pkg::FC_EXC_BIT) != 8'h00) begin
      status = mbrtu_pkg::ST_FRAME;
    end else if (pend_q == mbrtu_pkg::PEND_READ) begin
      if (cnt_q != ReadCnt) begin
        status = mbrtu_pkg::ST_FRAME;
      end else begin
        status  = mbrtu_pkg::ST_OK;
        data_ok = 1'b1;
      end
    end else begin
      status = (cnt_q != WriteCnt || mism_q) ? mbrtu_pkg::ST_FRAME : mbrtu_pkg::ST_OK;
    end
  end

  // Receive state and pending request update.
  always_comb begin
    pend_d = pend_q;
    rreg_d = rreg_q;
    rval_d = rval_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    tail_d = tail_q;
    head_d = head_q;
    pay_d  = pay_q;
    mism_d = mism_q;
    if (accept) begin
      if (func == mbrtu_pkg::FUNC_RX) begin
        if (cnt_q < MaxCnt) begin
          if (cnt_q >= CntW'(2)) begin
            crc_d = mbrtu_pkg::crc_feed(crc_q, tail_q[7:0]);
          end
          tail_d = {req_i.rx_byte, tail_q[15:8]};
          if (cnt_q == CntW'(0)) begin
            head_d[15:8] = req_i.rx_byte;
          end
          if (cnt_q == CntW'(1)) begin
            head_d[7:0] = req_i.rx_byte;
          end
          for (int i = 0; i < mbrtu_pkg::PAYLOAD_LEN; i++) begin
            if (cnt_q == CntW'(i + mbrtu_pkg::PAYLOAD_POS)) begin
              pay_d[i] = req_i.rx_byte;
            end
          end
          // Echo check of a write response against the request.
          if ((cnt_q == CntW'(2) && req_i.rx_byte != rreg_q[15:8]) ||
              (cnt_q == CntW'(3) && req_i.rx_byte != rreg_q[7:0]) ||
              (cnt_q == CntW'(4) && req_i.rx_byte != rval_q[15:8]) ||
              (cnt_q == CntW'(5) && req_i.rx_byte != rval_q[7:0])) begin
            mism_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        // A start or an end drops any partial response.
        cnt_d  = '0;
        crc_d  = mbrtu_pkg::CRC_INIT;
        tail_d = '0;
        head_d = '0;
        mism_d = 1'b0;
        for (int i = 0; i < mbrtu_pkg::PAYLOAD_LEN; i++) begin
          pay_d[i] = '0;
        end
        if (func == mbrtu_pkg::FUNC_READ) begin
          pend_d = mbrtu_pkg::PEND_READ;
          rreg_d = mbrtu_pkg::READ_START;
          rval_d = mbrtu_pkg::READ_COUNT;
        end else if (func == mbrtu_pkg::FUNC_WRITE) begin
          pend_d = mbrtu_pkg::PEND_WRITE;
          rreg_d = req_i.register_address;
          rval_d = req_i.write_value;
        end else begin
          pend_d = mbrtu_pkg::PEND_NONE;
          rreg_d = '0;
          rval_d = '0;
        end
      end
    end
  end

  // Command to the back end.
  always_comb begin
    q_push_o = accept && (func != mbrtu_pkg::FUNC_RX);
    q_entry_o.done   = (func == mbrtu_pkg::FUNC_END);
    q_entry_o.status = mbrtu_pkg::ST_OK;
    q_entry_o.fcode  = '0;
    q_entry_o.d0     = '0;
    q_entry_o.d1     = '0;
    q_entry_o.d2     = '0;
    if (func == mbrtu_pkg::FUNC_END) begin
      q_entry_o.status = status;
      if (data_ok) begin
        q_entry_o.d0 = {pay_q[0], pay_q[1]};
        q_entry_o.d1 = {pay_q[2], pay_q[3]};
        q_entry_o.d2 = {pay_q[4], pay_q[5]};
      end
    end else if (func == mbrtu_pkg::FUNC_READ) begin
      q_entry_o.fcode = mbrtu_pkg::FC_READ;
      q_entry_o.d0    = mbrtu_pkg::READ_START;
      q_entry_o.d1    = mbrtu_pkg::READ_COUNT;
    end else begin
      q_entry_o.fcode = mbrtu_pkg::FC_WRITE;
      q_entry_o.d0    = req_i.register_address;
      q_entry_o.d1    = req_i.write_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= mbrtu_pkg::PEND_NONE;
      rreg_q <= '0;
      rval_q <= '0;
      cnt_q  <= '0;
      crc_q  <= mbrtu_pkg::CRC_INIT;
      tail_q <= '0;
      head_q <= '0;
      mism_q <= 1'b0;
      for (int i = 0; i < mbrtu_pkg::PAYLOAD_LEN; i++) begin
        pay_q[i] <= '0;
      end
    end else begin
      pend_q <= pend_d;
      rreg_q <= rreg_d;
      rval_q <= rval_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      tail_q <= tail_d;
      head_q <= head_d;
      mism_q <= mism_d;
      pay_q  <= pay_d;
    end
  end

endmodule

FILE: design/mbrtu_back.sv
// Back end: turns queued commands into result beats through an output register.
module mbrtu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           slave_addr_i,
  input  mbrtu_pkg::q_status_t q_stat_i,
  input  mbrtu_pkg::cmd_t      q_head_i,
  output logic                 q_pop_o,
  mbrtu_rsp_if.source          rsp_o
);

  mbrtu_pkg::back_state_e state_q, state_d;
  logic [2:0]             idx_q, idx_d;
  logic [15:0]            crc_q, crc_d;
  logic [7:0]             fc_q, fc_d;
  logic [15:0]            reg_q, reg_d;
  logic [15:0]            val_q, val_d;
  logic                   ov_q, ov_d;
  logic                   okind_q, okind_d;
  logic [7:0]             otx_q, otx_d;
  logic                   olast_q, olast_d;
  mbrtu_pkg::status_e     ostat_q, ostat_d;
  logic [15:0]            on_q, on_d;
  logic [15:0]            op_q, op_d;
  logic [15:0]            ok_q, ok_d;
  logic                   slot_free;
  logic [7:0]             req_byte;

  assign slot_free = !ov_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbrtu_pkg::BK_IDLE: begin
        if (slot_free && !q_stat_i.empty && !q_head_i.done) begin
          state_d = mbrtu_pkg::BK_REQ;
        end
      end
      mbrtu_pkg::BK_REQ: begin
        if (slot_free && idx_q == mbrtu_pkg::REQ_LAST_IDX) begin
          state_d = mbrtu_pkg::BK_IDLE;
        end
      end
      default: state_d = mbrtu_pkg::BK_IDLE;
    endcase
  end

  // Request byte for the current position of the frame.
  always_comb begin
    case (idx_q)
      3'd1:    req_byte = fc_q;
      3'd2:    req_byte = reg_q[15:8];
      3'd3:    req_byte = reg_q[7:0];
      3'd4:    req_byte = val_q[15:8];
      3'd5:    req_byte = val_q[7:0];
      3'd6:    req_byte = crc_q[7:0];
      3'd7:    req_byte = crc_q[15:8];
      default: req_byte = slave_addr_i;
    endcase
  end

  // Queue pop, frame sequencing and output register load.
  always_comb begin
    q_pop_o = 1'b0;
    idx_d   = idx_q;
    crc_d   = crc_q;
    fc_d    = fc_q;
    reg_d   = reg_q;
    val_d   = val_q;
    ov_d    = ov_q && !rsp_o.ready;
    okind_d = okind_q;
    otx_d   = otx_q;
    olast_d = olast_q;
    ostat_d = ostat_q;
    on_d    = on_q;
    op_d    = op_q;
    ok_d    = ok_q;
    unique case (state_q)
      mbrtu_pkg::BK_IDLE: begin
        if (slot_free && !q_stat_i.empty) begin
          q_pop_o = 1'b1;
          ov_d    = 1'b1;
          if (q_head_i.done) begin
            okind_d = mbrtu_pkg::KIND_DONE;
            otx_d   = '0;
            olast_d = 1'b1;
            ostat_d = q_head_i.status;
            on_d    = q_head_i.d0;
            op_d    = q_head_i.d1;
            ok_d    = q_head_i.d2;
          end else begin
            // Address byte goes out as the request is taken.
            okind_d = mbrtu_pkg::KIND_TX;
            otx_d   = slave_addr_i;
            olast_d = 1'b0;
            ostat_d = mbrtu_pkg::ST_OK;
            on_d    = '0;
            op_d    = '0;
            ok_d    = '0;
            crc_d   = mbrtu_pkg::crc_feed(mbrtu_pkg::CRC_INIT, slave_addr_i);
            idx_d   = 3'd1;
            fc_d    = q_head_i.fcode;
            reg_d   = q_head_i.d0;
            val_d   = q_head_i.d1;
          end
        end
      end
      mbrtu_pkg::BK_REQ: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          okind_d = mbrtu_pkg::KIND_TX;
          otx_d   = req_byte;
          olast_d = (idx_q == mbrtu_pkg::REQ_LAST_IDX);
          ostat_d = mbrtu_pkg::ST_OK;
          on_d    = '0;
          op_d    = '0;
          ok_d    = '0;
          idx_d   = idx_q + 1'b1;
          // The CRC covers the six header bytes only.
          if (idx_q <= 3'd5) begin
            crc_d = mbrtu_pkg::crc_feed(crc_q, req_byte);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrtu_pkg::BK_IDLE;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    fc_q    <= fc_d;
    reg_q   <= reg_d;
    val_q   <= val_d;
    okind_q <= okind_d;
    otx_q   <= otx_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
    on_q    <= on_d;
    op_q    <= op_d;
    ok_q    <= ok_d;
  end

  assign rsp_o.valid      = ov_q;
  assign rsp_o.kind       = okind_q;
  assign rsp_o.tx_byte    = otx_q;
  assign rsp_o.last       = olast_q;
  assign rsp_o.status     = ostat_q;
  assign rsp_o.nitrogen   = on_q;
  assign rsp_o.phosphorus = op_q;
  assign rsp_o.potassium  = ok_q;

endmodule

FILE: design/modbus_rtu_master_transaction_unit.sv
// Modbus RTU master top level: front end, command queue, back end and APB register.
// Received bytes are taken one per cycle always; start and end items wait only while
// the 4-entry command queue is full. A start item yields 8 beats at one per cycle, an end
// item one beat, while ready holds; from an idle back end the first beat passes the queue
// and then the output register, whose one beat per cycle sets the sustained request rate.
// Reset clears the receive state, the queue and the output; slave_address resets to 1.
module modbus_rtu_master_transaction_unit #(
  parameter int MAX_FRAME_BYTES = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_req_if.sink   req_i,
  mbrtu_rsp_if.source rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 slave_sel;
  logic [7:0]           slave_q;
  logic                 q_push;
  logic                 q_pop;
  mbrtu_pkg::cmd_t      q_entry;
  mbrtu_pkg::cmd_t      q_head;
  mbrtu_pkg::q_status_t q_stat;
  logic                 cfg_wr;

  // APB register: slave address at word index zero.
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign slave_sel = (paddr[2] == mbrtu_pkg::REG_SLAVE_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'h01;
    end else if (cfg_wr && slave_sel) begin
      slave_q <= pwdata[7:0];
    end
  end

  assign prdata = slave_sel ? {24'h000000, slave_q} : 32'h0000_0000;

  mbrtu_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .slave_addr_i (slave_q),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  mbrtu_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  mbrtu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slave_addr_i (slave_q),
    .q_stat_i     (q_stat),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .rsp_o        (rsp_o)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("command pushed into a full queue");

  // The back end only pops a queue that holds an entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  // An accepted start item leaves a command waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready &&
     (req_i.func == mbrtu_pkg::FUNC_READ || req_i.func == mbrtu_pkg::FUNC_WRITE))
    |=> !q_stat.empty)
    else $error("start item left no queued request");

endmodule

FILE: bench/modbus_rtu_master_transaction_unit_checker.sv
// Scoreboard for the Modbus RTU master: watches both streams and the APB port, predicts beats.
package mbrtu_tb_pkg;
  import mbrtu_pkg::*;

  // Byte addresses of the configuration port.
  localparam logic [2:0] ADDR_SLAVE  = {REG_SLAVE_ADDR, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  // One byte of the Modbus CRC16, shifted in bit by bit from the LSB.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction
endpackage

module modbus_rtu_master_transaction_unit_checker #(
  parameter int FRAME_LIMIT = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrtu_req_if        req_i,
  mbrtu_rsp_if        rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          beats_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  typedef struct {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last;
    status_e            status;
    logic signed [15:0] nitrogen;
    logic signed [15:0] phosphorus;
    logic signed [15:0] potassium;
  } beat_t;

  beat_t owed_q[$];

  // Shadow copy of the master's register, request and receive state.
  logic [7:0]  slave_addr;
  pend_e       pend;
  logic [15:0] req_reg;
  logic [15:0] req_val;
  int          rx_count;
  logic [15:0] crc_run;
  logic [15:0] tail;
  logic [15:0] head;
  logic [7:0]  payload [PAYLOAD_LEN];
  logic        echo_bad;

  int fail_total;
  int reported;

  function automatic string beat_text(input beat_t b);
    return $sformatf("kind=%0d tx=%02h last=%0d st=%0d n=%0d p=%0d k=%0d", b.kind, b.tx_byte,
                     b.last, b.status, b.nitrogen, b.phosphorus, b.potassium);
  endfunction

  task automatic clear_frame();
    rx_count = 0;
    crc_run  = CRC_INIT;
    tail     = '0;
    head     = '0;
    echo_bad = 1'b0;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload[i] = '0;
    end
  endtask

  // Queue the eight request bytes, CRC low then high.
  task automatic queue_request(input logic [7:0] fcode);
    logic [7:0]  bytes [8];
    logic [15:0] crc;
    beat_t       b;
    bytes[0] = slave_addr;
    bytes[1] = fcode;
    bytes[2] = req_reg[15:8];
    bytes[3] = req_reg[7:0];
    bytes[4] = req_val[15:8];
    bytes[5] = req_val[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_step(crc, bytes[i]);
    end
    bytes[6] = crc[7:0];
    bytes[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      b.kind       = KIND_TX;
      b.tx_byte    = bytes[i];
      b.last       = (i == int'(REQ_LAST_IDX));
      b.status     = ST_OK;
      b.nitrogen   = '0;
      b.phosphorus = '0;
      b.potassium  = '0;
      owed_q.push_back(b);
    end
  endtask

  // Fold one received byte in; the last two bytes stay out of the CRC.
  task automatic take_rx(input logic [7:0] rb);
    if (rx_count < FRAME_LIMIT) begin
      if (rx_count >= 2) begin
        crc_run = crc16_step(crc_run, tail[7:0]);
      end
      tail = {rb, tail[15:8]};
      if (rx_count == 0) head[15:8] = rb;
      if (rx_count == 1) head[7:0] = rb;
      if (rx_count >= PAYLOAD_POS && rx_count < PAYLOAD_POS + PAYLOAD_LEN) begin
        payload[rx_count - PAYLOAD_POS] = rb;
      end
      if (rx_count == 2 && rb != req_reg[15:8]) echo_bad = 1'b1;
      if (rx_count == 3 && rb != req_reg[7:0]) echo_bad = 1'b1;
      if (rx_count == 4 && rb != req_val[15:8]) echo_bad = 1'b1;
      if (rx_count == 5 && rb != req_val[7:0]) echo_bad = 1'b1;
      rx_count++;
    end
  endtask

  // Completion: checks run in a fixed order, the first failing one wins.
  task automatic queue_completion();
    beat_t      b;
    logic [7:0] fc;
    logic       fc_ok;
    fc = head[7:0];
    fc_ok = (pend == PEND_READ && (fc & FC_MASK) == FC_READ) ||
            (pend == PEND_WRITE && (fc & FC_MASK) == FC_WRITE);
    b.kind       = KIND_DONE;
    b.tx_byte    = '0;
    b.last       = 1'b1;
    b.nitrogen   = '0;
    b.phosphorus = '0;
    b.potassium  = '0;
    if (rx_count < MIN_LEN) begin
      b.status = ST_SHORT;
    end else if (crc_run != tail) begin
      b.status = ST_CRC;
    end else if (head[15:8] != slave_addr) begin
      b.status = ST_ADDR;
    end else if (!fc_ok) begin
      b.status = ST_FUNC;
    end else if ((fc & FC_EXC_BIT) != 0) begin
      b.status = ST_FRAME;
    end else if (pend == PEND_READ) begin
      if (rx_count != READ_LEN) begin
        b.status = ST_FRAME;
      end else begin
        b.status     = ST_OK;
        b.nitrogen   = {payload[0], payload[1]};
        b.phosphorus = {payload[2], payload[3]};
        b.potassium  = {payload[4], payload[5]};
      end
    end else begin
      b.status = (rx_count != WRITE_LEN || echo_bad) ? ST_FRAME : ST_OK;
    end
    owed_q.push_back(b);
    pend    = PEND_NONE;
    req_reg = '0;
    req_val = '0;
    clear_frame();
  endtask

  task automatic predict_item();
    case (func_e'(req_i.func))
      FUNC_READ: begin
        clear_frame();
        pend    = PEND_READ;
        req_reg = READ_START;
        req_val = READ_COUNT;
        queue_request(FC_READ);
      end
      FUNC_WRITE: begin
        clear_frame();
        pend    = PEND_WRITE;
        req_reg = req_i.register_address;
        req_val = req_i.write_value;
        queue_request(FC_WRITE);
      end
      FUNC_RX:  take_rx(req_i.rx_byte);
      default:  queue_completion();
    endcase
  endtask

  task automatic check_beat();
    beat_t want;
    beat_t got;
    got.kind       = rsp_i.kind;
    got.tx_byte    = rsp_i.tx_byte;
    got.last       = rsp_i.last;
    got.status     = status_e'(rsp_i.status);
    got.nitrogen   = rsp_i.nitrogen;
    got.phosphorus = rsp_i.phosphorus;
    got.potassium  = rsp_i.potassium;
    if (owed_q.size() == 0) begin
      fail_total++;
      if (reported < 10) begin
        reported++;
        $display("unexpected beat: %s", beat_text(got));
      end
    end else begin
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte || got.last !== want.last ||
          got.status !== want.status || got.nitrogen !== want.nitrogen ||
          got.phosphorus !== want.phosphorus || got.potassium !== want.potassium) begin
        fail_total++;
        if (reported < 10) begin
          reported++;
          $display("beat mismatch: expected %s", beat_text(want));
          $display("               actual   %s", beat_text(got));
        end
      end
    end
  endtask

  // Beats leave before new items are predicted; they always belong to older items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr = 8'd1;
      pend       = PEND_NONE;
      req_reg    = '0;
      req_val    = '0;
      clear_frame();
      owed_q.delete();
      fail_total = 0;
      reported   = 0;
      fail_count_o <= 0;
      beats_owed_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        check_beat();
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_SLAVE) begin
        slave_addr = pwdata[7:0];
      end
      if (req_i.valid && req_i.ready) begin
        predict_item();
      end
      fail_count_o <= fail_total;
      beats_owed_o <= owed_q.size();
    end
  end

endmodule

FILE: bench/modbus_rtu_master_transaction_unit_tb.sv
// Testbench top for the Modbus RTU master: clock, reset, APB setup, request and response traffic.
module modbus_rtu_master_transaction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrtu_pkg::*;
  import mbrtu_tb_pkg::*;

  localparam int FRAME_LIMIT    = 50;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int beats_owed;
  int cycle_count = 0;
  int items_sent  = 0;

  logic       burst = 1'b0;
  logic       calm_phase = 1'b0;
  logic [7:0] slave_addr = 8'd1;
  logic [7:0] frame_q[$];

  mbrtu_req_if req_bus ();
  mbrtu_rsp_if rsp_bus ();

  modbus_rtu_master_transaction_unit #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  modbus_rtu_master_transaction_unit_checker #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .beats_owed_o(beats_owed)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Register values biased toward the signed and unsigned extremes.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One input beat, held until the block takes it.
  task automatic drive_item(input func_e f, input logic [15:0] ra, input logic [15:0] wv,
                            input logic [7:0] rb);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid            <= 1'b1;
    req_bus.func             <= f;
    req_bus.register_address <= ra;
    req_bus.write_value      <= wv;
    req_bus.rx_byte          <= rb;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic push_word(input logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endtask

  // Append the CRC of everything queued so far, low byte first.
  task automatic seal_frame();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_q[i]) begin
      crc = crc16_step(crc, frame_q[i]);
    end
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  // Received bytes, then the end of frame.
  task automatic send_frame();
    foreach (frame_q[i]) begin
      drive_item(FUNC_RX, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 frame_q[i]);
    end
    drive_item(FUNC_END, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(0, 255)));
  endtask

  // Response to a request of the given kind, mostly well formed, sometimes damaged.
  task automatic make_response(input pend_e kind, input logic [15:0] ra, input logic [15:0] wv);
    int         r;
    int         n;
    logic [7:0] fc;
    logic       bad_crc;
    frame_q.delete();
    bad_crc = 1'b0;
    fc = (kind == PEND_WRITE) ? FC_WRITE : FC_READ;
    frame_q.push_back(slave_addr);
    frame_q.push_back(fc);
    if (kind == PEND_WRITE) begin
      push_word(ra);
      push_word(wv);
    end else begin
      frame_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd6);
      repeat (3) push_word(pick_word());
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      // Well formed.
    end else if (r < 62) begin
      frame_q[0] = slave_addr ^ 8'($urandom_range(1, 255));
    end else if (r < 69) begin
      // Exception reply, often in its short three-byte form.
      frame_q[1] = fc | FC_EXC_BIT;
      if ($urandom_range(0, 1) == 1) begin
        while (frame_q.size() > 3) void'(frame_q.pop_back());
      end
    end else if (r < 75) begin
      frame_q[1] = 8'($urandom_range(0, 255));
    end else if (r < 82) begin
      if ($urandom_range(0, 1) == 1) frame_q.push_back(8'($urandom_range(0, 255)));
      else void'(frame_q.pop_back());
    end else if (r < 88) begin
      n = 2 + $urandom_range(0, 3);
      frame_q[n] = frame_q[n] ^ 8'($urandom_range(1, 255));
    end else if (r < 94) begin
      bad_crc = 1'b1;
    end else begin
      // Too short to be a frame: no CRC added.
      frame_q.delete();
      repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    seal_frame();
    if (bad_crc) begin
      n = frame_q.size() - 1 - $urandom_range(0, 1);
      frame_q[n] = frame_q[n] ^ (8'd1 << $urandom_range(0, 7));
    end
  endtask

  // One random transaction: request and response, noise, or an overlong frame.
  task automatic run_transaction();
    int          sel;
    logic [15:0] ra;
    logic [15:0] wv;
    sel   = $urandom_range(0, 99);
    burst = calm_phase || ($urandom_range(0, 4) == 0);
    // A request abandoned part way through its response.
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        drive_item(FUNC_READ, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
      end else begin
        drive_item(FUNC_WRITE, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 6)) begin
        drive_item(FUNC_RX, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
      end
    end
    if (sel < 45) begin
      drive_item(FUNC_READ, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
      make_response(PEND_READ, READ_START, READ_COUNT);
    end else if (sel < 85) begin
      ra = pick_word();
      wv = pick_word();
      drive_item(FUNC_WRITE, ra, wv, 8'($urandom_range(0, 255)));
      make_response(PEND_WRITE, ra, wv);
    end else if (sel < 94) begin
      make_response(PEND_NONE, 16'h0000, 16'h0000);
    end else begin
      // Sealed at exactly the frame limit, then trailing bytes that must be dropped.
      drive_item(FUNC_READ, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
      frame_q.delete();
      frame_q.push_back(slave_addr);
      frame_q.push_back(FC_READ);
      repeat (FRAME_LIMIT - 4) frame_q.push_back(8'($urandom_range(0, 255)));
      seal_frame();
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every owed beat, then let the pipeline run dry.
  task automatic drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (beats_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: a random stall before each beat.
  initial begin : rsp_drain
    int stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int phase_start;
    rst_ni                   <= 1'b0;
    req_bus.valid            <= 1'b0;
    req_bus.func             <= FUNC_READ;
    req_bus.register_address <= '0;
    req_bus.write_value      <= '0;
    req_bus.rx_byte          <= '0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to an unmapped register must leave the slave address alone.
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);

    // End of frame with nothing received and no request outstanding.
    drive_item(FUNC_END, 16'hFFFF, 16'hFFFF, 8'hFF);

    // Write request with extreme register and value, answered by an exact echo.
    drive_item(FUNC_WRITE, 16'hFFFF, 16'h0000, 8'h00);
    frame_q.delete();
    frame_q.push_back(slave_addr);
    frame_q.push_back(FC_WRITE);
    push_word(16'hFFFF);
    push_word(16'h0000);
    seal_frame();
    send_frame();

    // Read request answered with the signed extremes.
    drive_item(FUNC_READ, 16'h0000, 16'hFFFF, 8'hFF);
    frame_q.delete();
    frame_q.push_back(slave_addr);
    frame_q.push_back(FC_READ);
    frame_q.push_back(8'd6);
    push_word(16'h8000);
    push_word(16'h7FFF);
    push_word(16'hFFFF);
    seal_frame();
    send_frame();

    // Random traffic under several slave addresses; one phase runs without stalls.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1:       slave_addr = 8'h00;
          2:       slave_addr = 8'hFF;
          default: slave_addr = 8'($urandom_range(0, 255));
        endcase
        apb_write(ADDR_SLAVE, {24'($urandom_range(0, 24'hFF_FFFF)), slave_addr});
      end
      calm_phase  = (p == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        run_transaction();
      end
    end
    calm_phase = 1'b0;
    burst      = 1'b0;

    drain();
    if (fail_count == 0 && beats_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
